// ----- hw/rtl/gyro_frame_receiver_assert.svh -----
`ifndef GYRO_FRAME_RECEIVER_ASSERT_SVH
`define GYRO_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, held off during reset
`define GFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define GFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gfr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'h5A;
    localparam logic [7:0] TYPE_VEL = 8'hAA;
    localparam logic [7:0] TYPE_ANG = 8'hBB;

    typedef enum logic [2:0] {
        POS_IDLE = 3'd0,
        POS_TYPE = 3'd1,
        POS_LO   = 3'd2,
        POS_HI   = 3'd3,
        POS_SUM  = 3'd4
    } pos_t;

    typedef struct packed {
        logic               frame_done;
        logic               checksum_bad;
        logic signed [15:0] angle;
        logic signed [15:0] angular_velocity;
        logic               angle_valid;
        logic               velocity_valid;
        logic [31:0]        good_frames;
        logic [31:0]        checksum_errors;
    } gfr_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gfr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gfr_result_if;
    logic               valid;
    logic               ready;
    logic               frame_done;
    logic               checksum_bad;
    logic signed [15:0] angle;
    logic signed [15:0] angular_velocity;
    logic               angle_valid;
    logic               velocity_valid;
    logic [31:0]        good_frames;
    logic [31:0]        checksum_errors;

    modport source (
        output valid, output frame_done, output checksum_bad, output angle,
        output angular_velocity, output angle_valid, output velocity_valid,
        output good_frames, output checksum_errors, input ready
    );
    modport sink (
        input valid, input frame_done, input checksum_bad, input angle,
        input angular_velocity, input angle_valid, input velocity_valid,
        input good_frames, input checksum_errors, output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/gfr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gfr_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          rx_byte,
    output gfr_pkg::gfr_result_t     result
);
    import gfr_pkg::*;

    pos_t                   pos_reg, pos_next;
    logic [7:0]             type_reg, type_next;
    logic [7:0]             lo_reg, lo_next;
    logic [7:0]             hi_reg, hi_next;
    logic [15:0]            angle_reg, angle_next;
    logic [15:0]            velocity_reg, velocity_next;
    logic                   angle_valid_reg, angle_valid_next;
    logic                   velocity_valid_reg, velocity_valid_next;
    logic [COUNT_WIDTH-1:0] good_count_reg, good_count_next;
    logic [COUNT_WIDTH-1:0] error_count_reg, error_count_next;
    logic                   done;
    logic                   bad;
    logic [7:0]             sum;
    logic                   is_hdr;

    // header byte is always the first of a frame, so only three bytes are held
    assign sum    = HDR_BYTE + type_reg + lo_reg + hi_reg;
    assign is_hdr = (rx_byte == HDR_BYTE);

    always_comb
    begin
        pos_next            = pos_reg;
        type_next           = type_reg;
        lo_next             = lo_reg;
        hi_next             = hi_reg;
        angle_next          = angle_reg;
        velocity_next       = velocity_reg;
        angle_valid_next    = angle_valid_reg;
        velocity_valid_next = velocity_valid_reg;
        good_count_next     = good_count_reg;
        error_count_next    = error_count_reg;
        done                = 1'b0;
        bad                 = 1'b0;
        case (pos_reg)
            POS_TYPE:
            begin
                if (rx_byte inside {TYPE_ANG, TYPE_VEL})
                begin
                    type_next = rx_byte;
                    pos_next  = POS_LO;
                end
                else
                begin
                    // bad type: a header here opens a new frame
                    pos_next = is_hdr ? POS_TYPE : POS_IDLE;
                end
            end
            POS_LO:
            begin
                lo_next  = rx_byte;
                pos_next = POS_HI;
            end
            POS_HI:
            begin
                hi_next  = rx_byte;
                pos_next = POS_SUM;
            end
            POS_SUM:
            begin
                if (sum != rx_byte)
                begin
                    error_count_next = error_count_reg + 1'b1;
                    bad              = 1'b1;
                    pos_next         = is_hdr ? POS_TYPE : POS_IDLE;
                end
                else
                begin
                    if (type_reg == TYPE_ANG)
                    begin
                        angle_next       = {hi_reg, lo_reg};
                        angle_valid_next = 1'b1;
                    end
                    else
                    begin
                        velocity_next       = {hi_reg, lo_reg};
                        velocity_valid_next = 1'b1;
                    end
                    good_count_next = good_count_reg + 1'b1;
                    done            = 1'b1;
                    pos_next        = POS_IDLE;
                end
            end
            default:
            begin
                pos_next = is_hdr ? POS_TYPE : POS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg            <= POS_IDLE;
            angle_reg          <= '0;
            velocity_reg       <= '0;
            angle_valid_reg    <= 1'b0;
            velocity_valid_reg <= 1'b0;
            good_count_reg     <= '0;
            error_count_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg            <= pos_next;
            angle_reg          <= angle_next;
            velocity_reg       <= velocity_next;
            angle_valid_reg    <= angle_valid_next;
            velocity_valid_reg <= velocity_valid_next;
            good_count_reg     <= good_count_next;
            error_count_reg    <= error_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            type_reg <= type_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
    end

    always_comb
    begin
        result.frame_done       = done;
        result.checksum_bad     = bad;
        result.angle            = angle_next;
        result.angular_velocity = velocity_next;
        result.angle_valid      = angle_valid_next;
        result.velocity_valid   = velocity_valid_next;
        result.good_frames      = 32'(good_count_next);
        result.checksum_errors  = 32'(error_count_next);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gyro_frame_receiver.sv -----
// gyro_frame_receiver: byte-serial frame parser for a single-axis gyro
// rx channel: one received serial byte per beat (rx_byte)
// res channel: one result beat for every rx beat, in order; it carries the
//   frame_done / checksum_bad flags for that byte plus the current angle,
//   angular_velocity, their valid bits and the good / error frame counters
// frames are 5A, type (BB angle, AA velocity), value low, value high, sum
// a byte taken into the input register is parsed into the result register
// throughput: one byte per cycle while res.ready is high, set by the
//   single parse step between the input register and the result register
// reset: parser idle, angle and velocity zero and not valid, counters zero,
//   both pipeline registers empty
// stall: while res.ready is low the result beat holds; one more byte is
//   taken into the input register, then rx.ready drops until res drains
// counters are COUNT_WIDTH bits, wrap, and show their low 32 bits
`timescale 1ns / 1ps
`default_nettype none

module gyro_frame_receiver #(
    parameter int COUNT_WIDTH = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    gfr_byte_if.sink     rx,
    gfr_result_if.source res
);
    import gfr_pkg::*;

    logic        rx_valid_reg, rx_valid_next;
    logic [7:0]  rx_byte_reg;
    logic        res_valid_reg, res_valid_next;
    gfr_result_t result_reg;
    gfr_result_t result;
    logic        rx_take;
    logic        advance;

    // parse the held byte whenever the result register can take it
    assign advance  = rx_valid_reg && (!res_valid_reg || res.ready);
    assign rx.ready = !rx_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    gfr_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (rx_byte_reg),
        .result  (result)
    );

    always_comb
    begin
        if (rx_take)
            rx_valid_next = 1'b1;
        else if (advance)
            rx_valid_next = 1'b0;
        else
            rx_valid_next = rx_valid_reg;

        if (advance)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rx_valid_reg  <= rx_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (rx_take)
            rx_byte_reg <= rx.rx_byte;
        if (advance)
            result_reg <= result;
    end

    assign res.valid            = res_valid_reg;
    assign res.frame_done       = result_reg.frame_done;
    assign res.checksum_bad     = result_reg.checksum_bad;
    assign res.angle            = result_reg.angle;
    assign res.angular_velocity = result_reg.angular_velocity;
    assign res.angle_valid      = result_reg.angle_valid;
    assign res.velocity_valid   = result_reg.velocity_valid;
    assign res.good_frames      = result_reg.good_frames;
    assign res.checksum_errors  = result_reg.checksum_errors;

endmodule

`default_nettype wire

// ----- hw/rtl/gfr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_frame_receiver_assert.svh"

module gfr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        frame_done,
    input wire logic        checksum_bad,
    input wire logic        angle_valid,
    input wire logic        velocity_valid,
    input wire logic [31:0] good_frames
);

    // a byte ends a frame one way or the other, never both
    `GFR_ASSERT_IMPLY(a_done_xor_bad, clk, rst_n, res_valid,
        !(frame_done && checksum_bad), "frame_done and checksum_bad both set")

    // a good frame always leaves one of the values valid
    `GFR_ASSERT_IMPLY(a_done_sets_valid, clk, rst_n, res_valid && frame_done,
        angle_valid || velocity_valid, "good frame without a valid value")

    // valid bits are sticky until reset
    `GFR_ASSERT_NEXT(a_angle_sticky, clk, rst_n, res_valid && angle_valid,
        angle_valid, "angle_valid dropped")
    `GFR_ASSERT_NEXT(a_vel_sticky, clk, rst_n, res_valid && velocity_valid,
        velocity_valid, "velocity_valid dropped")

    // stalled result beat holds
    `GFR_ASSERT_NEXT(a_stall_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(good_frames), "stalled result beat changed")

endmodule

bind gyro_frame_receiver gfr_checker u_gfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .frame_done     (res.frame_done),
    .checksum_bad   (res.checksum_bad),
    .angle_valid    (res.angle_valid),
    .velocity_valid (res.velocity_valid),
    .good_frames    (res.good_frames)
);

`default_nettype wire

// ----- bench/tb_gyro_frame_receiver.sv -----
`timescale 1ns / 1ps

module tb_gyro_frame_receiver;
    import gfr_pkg::*;

    // shapes of random stimulus units
    typedef enum int {
        UNIT_GOOD,
        UNIT_BAD_SUM,
        UNIT_BAD_TYPE,
        UNIT_CUT,
        UNIT_NOISE
    } unit_kind_t;

    // receiver stall patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_BURSTY,
        RDY_PERIODIC
    } ready_mode_t;

    logic clk;
    logic rst_n;

    gfr_byte_if   rx_if ();
    gfr_result_if res_if ();

    gyro_frame_receiver #(
        .COUNT_WIDTH(32)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx_if),
        .res  (res_if)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // shadow copy of the parser state
    pos_t        frame_pos;
    logic [7:0]  held [4];
    logic [15:0] angle_shadow;
    logic [15:0] velocity_shadow;
    logic        angle_seen;
    logic        velocity_seen;
    logic [31:0] good_shadow;
    logic [31:0] error_shadow;

    // one expected result beat per accepted byte, oldest first
    gfr_result_t expected_results [$];

    int error_count;
    int bytes_sent;
    int frames_ok_seen;
    int frames_bad_seen;

    // sender burst control
    bit sender_gaps;
    int burst_left;

    // receiver stall control
    ready_mode_t ready_mode;
    int          stall_left;
    int unsigned cycle_count;

    // advance the shadow parser by one byte and return the result it causes
    function automatic gfr_result_t parse_rx_byte(input logic [7:0] b);
        gfr_result_t r;
        logic [7:0]  sum;
        r.frame_done   = 1'b0;
        r.checksum_bad = 1'b0;
        case (frame_pos)
            POS_TYPE:
            begin
                if (b != TYPE_ANG && b != TYPE_VEL)
                begin
                    // bad type drops the frame, a header byte restarts it
                    frame_pos = (b == HDR_BYTE) ? POS_TYPE : POS_IDLE;
                end
                else
                begin
                    held[1]   = b;
                    frame_pos = POS_LO;
                end
            end
            POS_LO:
            begin
                held[2]   = b;
                frame_pos = POS_HI;
            end
            POS_HI:
            begin
                held[3]   = b;
                frame_pos = POS_SUM;
            end
            POS_SUM:
            begin
                sum = held[0] + held[1] + held[2] + held[3];
                if (sum != b)
                begin
                    error_shadow   = error_shadow + 32'd1;
                    r.checksum_bad = 1'b1;
                    frame_pos      = (b == HDR_BYTE) ? POS_TYPE : POS_IDLE;
                end
                else
                begin
                    if (held[1] == TYPE_ANG)
                    begin
                        angle_shadow = {held[3], held[2]};
                        angle_seen   = 1'b1;
                    end
                    else
                    begin
                        velocity_shadow = {held[3], held[2]};
                        velocity_seen   = 1'b1;
                    end
                    good_shadow  = good_shadow + 32'd1;
                    r.frame_done = 1'b1;
                    frame_pos    = POS_IDLE;
                end
            end
            default:
            begin
                // idle: hunt for a header, drop anything else
                if (b == HDR_BYTE)
                begin
                    held[0]   = b;
                    frame_pos = POS_TYPE;
                end
                else
                begin
                    frame_pos = POS_IDLE;
                end
            end
        endcase
        r.angle            = angle_shadow;
        r.angular_velocity = velocity_shadow;
        r.angle_valid      = angle_seen;
        r.velocity_valid   = velocity_seen;
        r.good_frames      = good_shadow;
        r.checksum_errors  = error_shadow;
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // result checker, then capture of the byte accepted at this edge;
    // a byte's result never shows at its own edge, so this order is safe
    always @(posedge clk)
    begin
        gfr_result_t exp_r;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual frame_done %b",
                             $time, res_if.frame_done);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    report_field("frame_done", 32'(exp_r.frame_done),
                                 32'(res_if.frame_done));
                    report_field("checksum_bad", 32'(exp_r.checksum_bad),
                                 32'(res_if.checksum_bad));
                    report_field("angle", 32'(exp_r.angle), 32'(res_if.angle));
                    report_field("angular_velocity", 32'(exp_r.angular_velocity),
                                 32'(res_if.angular_velocity));
                    report_field("angle_valid", 32'(exp_r.angle_valid),
                                 32'(res_if.angle_valid));
                    report_field("velocity_valid", 32'(exp_r.velocity_valid),
                                 32'(res_if.velocity_valid));
                    report_field("good_frames", exp_r.good_frames, res_if.good_frames);
                    report_field("checksum_errors", exp_r.checksum_errors,
                                 res_if.checksum_errors);
                    if (exp_r.frame_done)
                        frames_ok_seen++;
                    if (exp_r.checksum_bad)
                        frames_bad_seen++;
                end
            end
            if (rx_if.valid && rx_if.ready)
                expected_results.push_back(parse_rx_byte(rx_if.rx_byte));
        end
    end

    // receiver side: ready follows the current stall pattern
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                RDY_BURSTY:
                begin
                    // runs of stalled cycles of random length
                    if (stall_left > 0)
                    begin
                        stall_left   <= stall_left - 1;
                        res_if.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        stall_left   <= $urandom_range(0, 7);
                        res_if.ready <= 1'b0;
                    end
                    else
                    begin
                        res_if.ready <= 1'b1;
                    end
                end
                RDY_PERIODIC:
                    // periodic stall pattern taken from cycle_count
                    res_if.ready <= ((cycle_count % 11) >= 3);
                default:
                    res_if.ready <= 1'b1;
            endcase
        end
    end

    // send one byte; with gaps on, waits out a random gap when the current burst ends
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (sender_gaps && burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] frame_sum(input logic [7:0] kind, input logic [15:0] value);
        return HDR_BYTE + kind + value[7:0] + value[15:8];
    endfunction

    task automatic send_frame(input logic [7:0] kind, input logic [15:0] value,
                              input logic [7:0] sum);
        send_byte(HDR_BYTE);
        send_byte(kind);
        send_byte(value[7:0]);
        send_byte(value[15:8]);
        send_byte(sum);
    endtask

    function automatic logic [15:0] pick_value();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h0000;
                1: return 16'h7FFF;
                2: return 16'h8000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [7:0] pick_type();
        return $urandom_range(0, 1) ? TYPE_ANG : TYPE_VEL;
    endfunction

    // one random unit: mostly good frames, then broken frames and noise
    task automatic send_random_unit();
        unit_kind_t  kind;
        int          roll;
        logic [7:0]  t;
        logic [7:0]  s;
        logic [7:0]  junk;
        logic [15:0] v;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            kind = UNIT_GOOD;
        else if (roll < 15)
            kind = UNIT_BAD_SUM;
        else if (roll < 17)
            kind = UNIT_BAD_TYPE;
        else if (roll < 18)
            kind = UNIT_CUT;
        else
            kind = UNIT_NOISE;
        t = pick_type();
        v = pick_value();
        s = frame_sum(t, v);
        case (kind)
            UNIT_GOOD:
                send_frame(t, v, s);
            UNIT_BAD_SUM:
            begin
                // a wrong sum, now and then a header byte that restarts the frame
                if ($urandom_range(0, 3) == 0 && s != HDR_BYTE)
                    send_frame(t, v, HDR_BYTE);
                else
                    send_frame(t, v, s ^ 8'($urandom_range(1, 255)));
            end
            UNIT_BAD_TYPE:
            begin
                junk = 8'($urandom_range(0, 255));
                while (junk == TYPE_ANG || junk == TYPE_VEL)
                    junk = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 2) == 0)
                    junk = HDR_BYTE;
                send_byte(HDR_BYTE);
                send_byte(junk);
            end
            UNIT_CUT:
            begin
                // frame broken off after one to three bytes
                send_byte(HDR_BYTE);
                if ($urandom_range(0, 1))
                    send_byte(t);
                if ($urandom_range(0, 1))
                    send_byte(v[7:0]);
            end
            default:
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_unit();
    endtask

    // idle bytes outside a frame are dropped
    task automatic test_noise_dropped();
        send_byte(8'hFF);
    endtask

    // angle frame with the largest positive value
    task automatic test_angle_frame();
        send_frame(TYPE_ANG, 16'h7FFF, frame_sum(TYPE_ANG, 16'h7FFF));
    endtask

    // velocity frame with the most negative value
    task automatic test_velocity_frame();
        send_frame(TYPE_VEL, 16'h8000, frame_sum(TYPE_VEL, 16'h8000));
    endtask

    // bad type that is a header restarts, bad type that is not goes idle
    task automatic test_bad_type();
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'h00);
    endtask

    // wrong checksum equal to the header starts the next frame at once
    task automatic test_checksum_resync();
        send_frame(TYPE_ANG, 16'h0000, HDR_BYTE);
        send_byte(TYPE_VEL);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(frame_sum(TYPE_VEL, 16'h0001));
    endtask

    // bursty sender against a randomly stalling receiver
    task automatic test_random_bursty();
        sender_gaps = 1'b1;
        ready_mode  = RDY_BURSTY;
        run_random(900);
    endtask

    // back to back bytes with no idling on either side
    task automatic test_random_streaming();
        sender_gaps = 1'b0;
        ready_mode  = RDY_ALWAYS;
        run_random(400);
    endtask

    // full rate sender against a periodic stall, then both idling
    task automatic test_random_periodic();
        sender_gaps = 1'b0;
        ready_mode  = RDY_PERIODIC;
        run_random(350);
        sender_gaps = 1'b1;
        run_random(350);
    endtask

    // shadow state at reset
    initial
    begin
        frame_pos       = POS_IDLE;
        held[0]         = '0;
        held[1]         = '0;
        held[2]         = '0;
        held[3]         = '0;
        angle_shadow    = '0;
        velocity_shadow = '0;
        angle_seen      = 1'b0;
        velocity_seen   = 1'b0;
        good_shadow     = '0;
        error_shadow    = '0;
        error_count     = 0;
        bytes_sent      = 0;
        frames_ok_seen  = 0;
        frames_bad_seen = 0;
        cycle_count     = 0;
        stall_left      = 0;
        burst_left      = 0;
        sender_gaps     = 1'b1;
        ready_mode      = RDY_BURSTY;
    end

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = 8'h00;
        res_if.ready   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_noise_dropped();
        test_angle_frame();
        test_velocity_frame();
        test_bad_type();
        test_checksum_resync();
        test_random_bursty();
        test_random_streaming();
        test_random_periodic();

        rx_if.valid <= 1'b0;
        ready_mode  = RDY_ALWAYS;
        while (expected_results.size() != 0)
            @(posedge clk);
        // slack for a stray beat
        repeat (8) @(posedge clk);

        $display("tb_gyro_frame_receiver: %0d bytes sent, %0d good and %0d bad-sum frames",
                 bytes_sent, frames_ok_seen, frames_bad_seen);
        $display("tb_gyro_frame_receiver: bursty, streaming and periodic stall traffic");
        if (error_count == 0)
            $display("tb_gyro_frame_receiver: done, clean");
        else
            $display("tb_gyro_frame_receiver: done, errors");
        $finish;
    end

    // hang guard, far past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb_gyro_frame_receiver: done, errors");
        $finish;
    end

endmodule
